>>> rtl/core/i2rd_pkg.sv
// ----------------------------------------------------------------------------
// i2rd_pkg: shared types and constants for the radix digit converter
// Holds the queue item and status structs, radix limits and the digit glyph
// mapping used by the front, the queue, the back end and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package i2rd_pkg;

	// magnitude of a positive 32-bit signed value
	localparam int MAG_W = 31;
	localparam int VALUE_W = 32;
	localparam int RADIX_W = 6;
	localparam int CHAR_W = 7;
	localparam int DIGIT_W = 6;
	localparam int BIT_CNT_W = 5;
	localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(MAG_W - 1);

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd2;

	// queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [DIGIT_W-1:0] DIGIT_MAX_DEC = 6'd9;
	localparam logic [CHAR_W-1:0] GLYPH_DEC_BASE = 7'd48;
	localparam logic [CHAR_W-1:0] GLYPH_ALPHA_BASE = 7'd55;
	localparam logic [CHAR_W-1:0] CHAR_DEC_FIRST = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_DEC_LAST = 7'd57;
	localparam logic [CHAR_W-1:0] CHAR_ALPHA_FIRST = 7'd65;
	localparam logic [CHAR_W-1:0] CHAR_ALPHA_LAST = 7'd90;

	typedef struct packed {
		logic             valid;
		logic [MAG_W-1:0] mag;
	} i2rd_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} i2rd_qstat_t;

	// map a digit value to its ASCII character
	function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = {1'b0, d};
		if (d <= DIGIT_MAX_DEC) begin
			return GLYPH_DEC_BASE + dx;
		end else begin
			return GLYPH_ALPHA_BASE + dx;
		end
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/integer_to_radix_digits_core.sv
// ----------------------------------------------------------------------------
// integer_to_radix_digits_core: signed integer to ASCII digits in base 2..36
// Top level joining the input front, the magnitude queue and the back end.
// ----------------------------------------------------------------------------
// Each beat on the input carries a signed 32-bit value. Values of zero or
// below produce no output. A positive value produces its digits in the
// current radix, most significant first, as ASCII '0'..'9' and 'A'..'Z',
// with last_digit set on the final digit. The radix register takes writes
// through radix_we / radix_wdata; writes below 2 store 2 and above 36 store
// 36; reset value is 2. Write it only while no conversion is in flight.
// The back end divides with one quotient bit per cycle, so each digit costs
// 31 division steps; each digit is then read back from the digit store and
// loaded into the output register. A value has up to 31 digits, in base 2.
// Up to three further values wait in the queue and the input stage while
// one is converted.
// Results beyond MAX_DIGITS digits are cut to the least significant ones.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_digits_core #(
	parameter int MAX_DIGITS = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [i2rd_pkg::VALUE_W-1:0]   value,
	input  wire logic                                  radix_we,
	input  wire logic [i2rd_pkg::RADIX_W-1:0]          radix_wdata,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [i2rd_pkg::CHAR_W-1:0]                digit_char,
	output logic                                       last_digit
);

	i2rd_pkg::i2rd_item_t            push;
	i2rd_pkg::i2rd_qstat_t           qstat;
	logic                            pop;
	logic [i2rd_pkg::MAG_W-1:0]      head;
	logic [i2rd_pkg::RADIX_W-1:0]    radix;

	i2rd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.value       (value),
		.radix_we    (radix_we),
		.radix_wdata (radix_wdata),
		.qstat       (qstat),
		.push        (push),
		.radix       (radix)
	);

	i2rd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.qstat  (qstat),
		.head   (head)
	);

	i2rd_back #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.head       (head),
		.pop        (pop),
		.radix      (radix),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digit_char (digit_char),
		.last_digit (last_digit)
	);

	// back end never pops an empty queue
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

	// the input stalls only while the front holds a beat for a full queue
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (push.valid && qstat.full))
		else $error("input stalled without a full queue");

	// emitted characters are legal digit glyphs
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((digit_char >= i2rd_pkg::CHAR_DEC_FIRST &&
			digit_char <= i2rd_pkg::CHAR_DEC_LAST) ||
			(digit_char >= i2rd_pkg::CHAR_ALPHA_FIRST &&
			digit_char <= i2rd_pkg::CHAR_ALPHA_LAST)))
		else $error("digit character out of range");

endmodule

`default_nettype wire

>>> rtl/core/i2rd_front.sv
// ----------------------------------------------------------------------------
// i2rd_front: input stage and radix register
// Accepts input beats, drops values of zero or below, and holds each positive
// magnitude in one stage until the queue takes it. Holds the clamped radix.
// ----------------------------------------------------------------------------
`default_nettype none

module i2rd_front (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [i2rd_pkg::VALUE_W-1:0]    value,
	input  wire logic                                   radix_we,
	input  wire logic [i2rd_pkg::RADIX_W-1:0]           radix_wdata,
	input  wire i2rd_pkg::i2rd_qstat_t                  qstat,
	output i2rd_pkg::i2rd_item_t                        push,
	output logic [i2rd_pkg::RADIX_W-1:0]                radix
);

	logic                          valid_s1;
	logic [i2rd_pkg::MAG_W-1:0]    mag_s1;
	logic [i2rd_pkg::RADIX_W-1:0]  radix_q;
	logic                          accept;
	logic                          keep;
	logic                          move;

	// stall only while the stage is held by a full queue
	assign in_stall = valid_s1 & qstat.full;
	assign accept   = in_valid & ~in_stall;
	assign keep     = accept & ~value[i2rd_pkg::VALUE_W-1] & (value != '0);
	assign move     = valid_s1 & ~qstat.full;

	assign push.valid = valid_s1;
	assign push.mag   = mag_s1;
	assign radix      = radix_q;

	// advance the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (keep) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (keep) begin
			mag_s1 <= value[i2rd_pkg::MAG_W-1:0];
		end
	end

	// clamp radix writes into the legal range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= i2rd_pkg::RADIX_RESET;
		end else if (radix_we) begin
			if (radix_wdata < i2rd_pkg::RADIX_MIN) begin
				radix_q <= i2rd_pkg::RADIX_MIN;
			end else if (radix_wdata > i2rd_pkg::RADIX_MAX) begin
				radix_q <= i2rd_pkg::RADIX_MAX;
			end else begin
				radix_q <= radix_wdata;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/i2rd_queue.sv
// ----------------------------------------------------------------------------
// i2rd_queue: short magnitude queue
// Register FIFO between the front and the back end so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module i2rd_queue (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire i2rd_pkg::i2rd_item_t         push,
	input  wire logic                         pop,
	output i2rd_pkg::i2rd_qstat_t             qstat,
	output logic [i2rd_pkg::MAG_W-1:0]        head
);

	logic [i2rd_pkg::MAG_W-1:0]   slot_q [i2rd_pkg::Q_DEPTH];
	logic [i2rd_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [i2rd_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [i2rd_pkg::Q_CNT_W-1:0] cnt_q;
	logic                         do_push;
	logic                         do_pop;

	assign qstat.full  = (cnt_q == i2rd_pkg::Q_CNT_W'(i2rd_pkg::Q_DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign do_push     = push.valid & ~qstat.full;
	assign do_pop      = pop & ~qstat.empty;
	assign head        = slot_q[rd_ptr_q];

	// store the pushed beat
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.mag;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/i2rd_back.sv
// ----------------------------------------------------------------------------
// i2rd_back: division and digit emission
// Takes magnitudes from the queue, divides them by the radix one quotient
// bit per cycle, stores each remainder, then emits the digits in reverse
// order through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module i2rd_back #(
	parameter int MAX_DIGITS = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire i2rd_pkg::i2rd_qstat_t              qstat,
	input  wire logic [i2rd_pkg::MAG_W-1:0]         head,
	output logic                                    pop,
	input  wire logic [i2rd_pkg::RADIX_W-1:0]       radix,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [i2rd_pkg::CHAR_W-1:0]             digit_char,
	output logic                                    last_digit
);

	localparam int IDX_W = $clog2(MAX_DIGITS);
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_DIGITS - 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DIV   = 4'b0010,
		ST_FETCH = 4'b0100,
		ST_EMIT  = 4'b1000
	} i2rd_state_t;

	i2rd_state_t                     state_q;
	logic [i2rd_pkg::MAG_W-1:0]      quo_q;
	logic [i2rd_pkg::DIGIT_W-1:0]    rem_q;
	logic [i2rd_pkg::BIT_CNT_W-1:0]  bit_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [IDX_W-1:0]                rd_idx_q;
	logic [i2rd_pkg::DIGIT_W-1:0]    rd_data_q;
	logic [i2rd_pkg::DIGIT_W-1:0]    store_mem [MAX_DIGITS];
	logic                            out_valid_q;
	logic [i2rd_pkg::CHAR_W-1:0]     char_q;
	logic                            last_q;

	logic [i2rd_pkg::DIGIT_W:0]      r2;
	logic [i2rd_pkg::DIGIT_W:0]      rdx;
	logic                            ge;
	logic [i2rd_pkg::DIGIT_W-1:0]    rem_nx;
	logic [i2rd_pkg::MAG_W-1:0]      quo_nx;
	logic                            digit_done;
	logic                            out_free;
	logic                            load_out;

	// one restoring division step
	assign r2     = {rem_q, quo_q[i2rd_pkg::MAG_W-1]};
	assign rdx    = {1'b0, radix};
	assign ge     = (r2 >= rdx);
	assign rem_nx = ge ? i2rd_pkg::DIGIT_W'(r2 - rdx) : r2[i2rd_pkg::DIGIT_W-1:0];
	assign quo_nx = {quo_q[i2rd_pkg::MAG_W-2:0], ge};

	assign digit_done = (state_q == ST_DIV) && (bit_q == i2rd_pkg::BIT_LAST);
	assign pop        = (state_q == ST_IDLE) && !qstat.empty;
	assign out_free   = ~out_valid_q | ~out_stall;
	assign load_out   = (state_q == ST_EMIT) && out_free;

	assign out_valid  = out_valid_q;
	assign digit_char = char_q;
	assign last_digit = last_q;

	// digit store: write a remainder per finished digit
	always_ff @(posedge clk) begin
		if (digit_done) begin
			store_mem[cnt_q[IDX_W-1:0]] <= rem_nx;
		end
	end

	// digit store: registered read
	always_ff @(posedge clk) begin
		if (state_q == ST_FETCH) begin
			rd_data_q <= store_mem[rd_idx_q];
		end
	end

	// sequence division and emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			quo_q    <= '0;
			rem_q    <= '0;
			bit_q    <= '0;
			cnt_q    <= '0;
			rd_idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						quo_q   <= head;
						rem_q   <= '0;
						bit_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					quo_q <= quo_nx;
					if (digit_done) begin
						rem_q <= '0;
						bit_q <= '0;
						cnt_q <= cnt_q + 1'b1;
						// stop on a zero quotient or a full store
						if (quo_nx == '0 || cnt_q == CNT_FULL) begin
							rd_idx_q <= cnt_q[IDX_W-1:0];
							state_q  <= ST_FETCH;
						end
					end else begin
						rem_q <= rem_nx;
						bit_q <= bit_q + 1'b1;
					end
				end
				ST_FETCH: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (rd_idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q - 1'b1;
							state_q  <= ST_FETCH;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register: hold while stalled, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			char_q <= i2rd_pkg::glyph(rd_data_q);
			last_q <= (rd_idx_q == '0);
		end
	end

endmodule

`default_nettype wire
